[sv/ascii_decimal_to_fixed_point_macros.svh]
// ----------------------------------------------------------------------------
// ascii_decimal_to_fixed_point_macros
// Assertion helpers shared by the parser blocks.
// ----------------------------------------------------------------------------
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASCII_DECIMAL_TO_FIXED_POINT_MACROS_SVH
`define ASCII_DECIMAL_TO_FIXED_POINT_MACROS_SVH

// Same-cycle implication.
`define ADFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ADFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/adfp_pkg.sv]
// ----------------------------------------------------------------------------
// adfp_pkg
// Types, character codes and constant tables of the decimal-to-fixed parser.
// ----------------------------------------------------------------------------
package adfp_pkg;

  localparam int INT_BITS_DEF        = 31;
  localparam int FRAC_BITS_DEF       = 32;
  localparam int MAX_FRAC_DIGITS_DEF = 15;

  // Widest fields a number record has to carry across the queue
  localparam int INT_BITS_MAX = 31;
  localparam int FACC_W_MAX   = 50;
  localparam int FCNT_W       = 4;
  localparam int VALUE_W      = 64;
  localparam int Q_DEPTH      = 2;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SIGNED = 3'd1,
    PH_ZERO   = 3'd2,
    PH_INT    = 3'd3,
    PH_FRAC   = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0] char_code;
  } char_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [7:0]                terminator;
    logic                      overflowed;
    logic                      digits_dropped;
  } number_item_t;

  // A finished number as the front hands it to the back
  typedef struct packed {
    logic                    negative;
    logic [INT_BITS_MAX-1:0] int_acc;
    logic [FACC_W_MAX-1:0]   frac_acc;
    logic [FCNT_W-1:0]       frac_count;
    logic [7:0]              terminator;
    logic                    overflowed;
    logic                    digits_dropped;
  } num_rec_t;

  function automatic logic [63:0] pow_ten(input logic [FCNT_W-1:0] n);
    logic [63:0] p;
    unique case (n)
      4'd0:    p = 64'd1;
      4'd1:    p = 64'd10;
      4'd2:    p = 64'd100;
      4'd3:    p = 64'd1000;
      4'd4:    p = 64'd10000;
      4'd5:    p = 64'd100000;
      4'd6:    p = 64'd1000000;
      4'd7:    p = 64'd10000000;
      4'd8:    p = 64'd100000000;
      4'd9:    p = 64'd1000000000;
      4'd10:   p = 64'd10000000000;
      4'd11:   p = 64'd100000000000;
      4'd12:   p = 64'd1000000000000;
      4'd13:   p = 64'd10000000000000;
      4'd14:   p = 64'd100000000000000;
      default: p = 64'd1000000000000000;
    endcase
    return p;
  endfunction

endpackage

[sv/adfp_stream_if.sv]
// ----------------------------------------------------------------------------
// adfp_stream_if
// Valid/ready word channel with a typed payload.
// ----------------------------------------------------------------------------
interface adfp_stream_if #(
  parameter type payload_t = logic [7:0]
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

[sv/ascii_decimal_to_fixed_point.sv]
// Path: a terminating word pushes its number record into the queue; the back pops it into
// its divider registers and, once the quotient is done, loads the output register.
// Throughput: one character word a cycle while the queue has room; the bit-serial
// fraction divider holds each fractional number till done; a 2-entry queue absorbs them.
// Reset: synchronous, active high; clears the parser to idle, empties queue and output.
// ----------------------------------------------------------------------------
// ascii_decimal_to_fixed_point
// ASCII decimal text to signed fixed point: parser front, record queue, divider back.
// ----------------------------------------------------------------------------
module ascii_decimal_to_fixed_point
  import adfp_pkg::*;
#(
  parameter int INT_BITS        = INT_BITS_DEF,
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  adfp_stream_if.sink   text,
  adfp_stream_if.source number
);

  logic     q_ready;
  logic     push;
  num_rec_t push_rec;
  logic     pop_valid;
  num_rec_t pop_rec;
  logic     pop;

  adfp_front #(
    .INT_BITS        (INT_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .text     (text),
    .q_ready  (q_ready),
    .push     (push),
    .push_rec (push_rec)
  );

  adfp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .q_ready   (q_ready),
    .pop_valid (pop_valid),
    .pop_rec   (pop_rec),
    .pop       (pop)
  );

  adfp_back #(
    .INT_BITS        (INT_BITS),
    .FRAC_BITS       (FRAC_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_rec   (pop_rec),
    .pop       (pop),
    .number    (number)
  );

endmodule

[sv/adfp_front.sv]
// ----------------------------------------------------------------------------
// adfp_front
// Character parser: tracks sign, integer and fraction digits one word a cycle while the
// queue has room, and pushes a finished number record when a terminator arrives.
// ----------------------------------------------------------------------------
`include "ascii_decimal_to_fixed_point_macros.svh"

module adfp_front
  import adfp_pkg::*;
#(
  parameter int INT_BITS        = INT_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  adfp_stream_if.sink        text,
  input  logic               q_ready,
  output logic               push,
  output num_rec_t           push_rec
);

  localparam int FACC_W = $clog2(pow_ten(FCNT_W'(MAX_FRAC_DIGITS)));

  typedef struct packed {
    logic emit;
    logic set_neg;
    logic int_add;
    logic frac_add;
    logic drop;
  } front_act_t;

  phase_t              phase, phase_next;
  logic                negative;
  logic [INT_BITS-1:0] int_acc;
  logic [FACC_W-1:0]   frac_acc;
  logic [FCNT_W-1:0]   frac_count;
  logic                ovf;
  logic                drop;

  front_act_t          act;
  logic                accept;
  logic [7:0]          c;
  logic [7:0]          c_off;
  logic [3:0]          digit_val;
  logic                is_digit, is_zero, is_nz, is_point, is_minus;
  logic                frac_room;
  phase_t              body_phase;
  logic [INT_BITS+3:0] int_prod;
  logic                int_over;
  logic [FACC_W+3:0]   frac_prod;

  assign text.ready = q_ready;
  assign accept     = text.valid && text.ready;
  assign c          = text.data.char_code;
  assign c_off      = c - CH_ZERO;
  assign digit_val  = c_off[3:0];
  assign is_digit   = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_zero    = (c == CH_ZERO);
  assign is_nz      = is_digit && !is_zero;
  assign is_point   = (c == CH_POINT);
  assign is_minus   = (c == CH_MINUS);
  assign frac_room  = frac_count < FCNT_W'(MAX_FRAC_DIGITS);

  // accumulate times ten as two shifts and an add
  assign int_prod  = ({4'b0, int_acc} << 3) + ({4'b0, int_acc} << 1)
                   + (INT_BITS+4)'(digit_val);
  assign int_over  = |int_prod[INT_BITS+3:INT_BITS];
  assign frac_prod = ({4'b0, frac_acc} << 3) + ({4'b0, frac_acc} << 1)
                   + (FACC_W+4)'(digit_val);

  always_comb begin
    if (is_zero) begin
      body_phase = PH_ZERO;
    end else if (is_nz) begin
      body_phase = PH_INT;
    end else if (is_point) begin
      body_phase = PH_FRAC;
    end else begin
      body_phase = PH_IDLE;
    end
  end

  always_comb begin
    unique case (phase)
      PH_SIGNED: phase_next = body_phase;
      PH_ZERO:   phase_next = is_point ? PH_FRAC : PH_IDLE;
      PH_INT:    phase_next = is_digit ? PH_INT : (is_point ? PH_FRAC : PH_IDLE);
      PH_FRAC:   phase_next = is_digit ? PH_FRAC : PH_IDLE;
      default:   phase_next = is_minus ? PH_SIGNED : body_phase;
    endcase
  end

  always_comb begin
    act = '0;
    unique case (phase)
      PH_SIGNED: begin
        act.int_add = is_nz;
        act.emit    = !is_digit && !is_point;
      end
      PH_ZERO: begin
        act.emit = !is_point;
      end
      PH_INT: begin
        act.int_add = is_digit;
        act.emit    = !is_digit && !is_point;
      end
      PH_FRAC: begin
        act.frac_add = is_digit && frac_room;
        act.drop     = is_digit && !frac_room;
        act.emit     = !is_digit;
      end
      default: begin
        act.set_neg = is_minus;
        act.int_add = is_nz;
        act.emit    = !is_minus && !is_digit && !is_point;
      end
    endcase
  end

  assign push = accept && act.emit;

  always_comb begin
    push_rec                = '0;
    push_rec.negative       = negative;
    push_rec.int_acc        = INT_BITS_MAX'(int_acc);
    push_rec.frac_acc       = FACC_W_MAX'(frac_acc);
    push_rec.frac_count     = frac_count;
    push_rec.terminator     = c;
    push_rec.overflowed     = ovf;
    push_rec.digits_dropped = drop;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      negative   <= 1'b0;
      int_acc    <= '0;
      frac_acc   <= '0;
      frac_count <= '0;
      ovf        <= 1'b0;
      drop       <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      if (act.emit) begin
        negative   <= 1'b0;
        int_acc    <= '0;
        frac_acc   <= '0;
        frac_count <= '0;
        ovf        <= 1'b0;
        drop       <= 1'b0;
      end else begin
        if (act.set_neg) begin
          negative <= 1'b1;
        end
        if (act.int_add) begin
          // saturate at the all-ones integer
          if (int_over) begin
            int_acc <= '1;
            ovf     <= 1'b1;
          end else begin
            int_acc <= int_prod[INT_BITS-1:0];
          end
        end
        if (act.frac_add) begin
          frac_acc   <= frac_prod[FACC_W-1:0];
          frac_count <= frac_count + 1'b1;
        end
        if (act.drop) begin
          drop <= 1'b1;
        end
      end
    end
  end

  `ADFP_ASSERT_NEXT(a_emit_clears, push, (phase == PH_IDLE) && !negative && (frac_count == '0),
    "front state not cleared after a number ended")
  `ADFP_ASSERT_NOW(a_frac_count_limit, 1'b1, frac_count <= FCNT_W'(MAX_FRAC_DIGITS),
    "fraction digit count beyond limit")
  `ADFP_ASSERT_NEXT(a_ovf_saturates, ovf && !push, int_acc == '1,
    "integer overflow flag set without saturated accumulator")

endmodule

[sv/adfp_queue.sv]
// ----------------------------------------------------------------------------
// adfp_queue
// Short show-ahead queue of number records between parser and divider.
// ----------------------------------------------------------------------------
`include "ascii_decimal_to_fixed_point_macros.svh"

module adfp_queue
  import adfp_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  num_rec_t push_rec,
  output logic     q_ready,
  output logic     pop_valid,
  output num_rec_t pop_rec,
  input  logic     pop
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  num_rec_t           slots [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign q_ready   = count != CNT_W'(Q_DEPTH);
  assign pop_valid = count != '0;
  assign pop_rec   = slots[rd_ptr];
  assign do_push   = push && q_ready;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ADFP_ASSERT_NOW(a_no_push_full, push, q_ready, "record pushed into a full queue")
  `ADFP_ASSERT_NOW(a_no_pop_empty, pop, pop_valid, "record popped from an empty queue")

endmodule

[sv/adfp_back.sv]
// ----------------------------------------------------------------------------
// adfp_back
// Fraction divider and result stage: one quotient bit a cycle of
// floor(D * 2^FRAC_BITS / 10^n), then sign and output register.
// ----------------------------------------------------------------------------
`include "ascii_decimal_to_fixed_point_macros.svh"

module adfp_back
  import adfp_pkg::*;
#(
  parameter int INT_BITS        = INT_BITS_DEF,
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          pop_valid,
  input  num_rec_t      pop_rec,
  output logic          pop,
  adfp_stream_if.source number
);

  localparam int FACC_W = $clog2(pow_ten(FCNT_W'(MAX_FRAC_DIGITS)));
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);

  logic                 busy;
  logic [CNT_W-1:0]     count;
  logic [FACC_W-1:0]    rem;
  logic [FACC_W-1:0]    divisor;
  logic [FRAC_BITS-1:0] quot;
  num_rec_t             cur;

  logic                 done, out_free, xfer;
  logic [63:0]          pow_full;
  logic [FACC_W:0]      rem_sh;
  logic                 take;
  logic [VALUE_W-1:0]   mag;

  assign done     = busy && (count == '0);
  assign out_free = !number.valid || number.ready;
  assign xfer     = done && out_free;
  assign pop      = pop_valid && (!busy || xfer);
  assign pow_full = pow_ten(pop_rec.frac_count);
  assign rem_sh   = {rem, 1'b0};
  assign take     = rem_sh >= {1'b0, divisor};

  always_comb begin
    mag = '0;
    mag[FRAC_BITS +: INT_BITS] = cur.int_acc[INT_BITS-1:0];
    mag[FRAC_BITS-1:0]         = quot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (pop) begin
      busy  <= 1'b1;
      // no fraction digits: quotient stays zero
      count <= (pop_rec.frac_count == '0) ? '0 : CNT_W'(FRAC_BITS);
    end else if (xfer) begin
      busy <= 1'b0;
    end else if (busy && count != '0) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur     <= pop_rec;
      rem     <= pop_rec.frac_acc[FACC_W-1:0];
      divisor <= pow_full[FACC_W-1:0];
      quot    <= '0;
    end else if (busy && count != '0) begin
      quot <= {quot[FRAC_BITS-2:0], take};
      if (take) begin
        rem <= FACC_W'(rem_sh - {1'b0, divisor});
      end else begin
        rem <= rem_sh[FACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      number.valid <= 1'b0;
    end else if (xfer) begin
      number.valid <= 1'b1;
    end else if (number.ready) begin
      number.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      number.data.value          <= cur.negative ? -mag : mag;
      number.data.terminator     <= cur.terminator;
      number.data.overflowed     <= cur.overflowed;
      number.data.digits_dropped <= cur.digits_dropped;
    end
  end

  `ADFP_ASSERT_NEXT(a_done_held, done && !out_free, done,
    "finished number lost while the output was stalled")
  `ADFP_ASSERT_NEXT(a_xfer_shows, xfer, number.valid,
    "finished number did not reach the output register")

endmodule
